// ----- rtl/tcsb_pkg.sv -----
// Shared types and codes for the text console scrollback buffer.
package tcsb_pkg;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_NEWLINE,
    S_LOCATE,
    S_BASE,
    S_PUT,
    S_BS,
    S_READ,
    S_CAPTURE,
    S_BLANK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    JOB_CHAR,
    JOB_BS,
    JOB_READ,
    JOB_BLANK
  } job_t;

  typedef enum logic [1:0] {
    COL_CURSOR,
    COL_CURSOR_DEC,
    COL_READ,
    COL_SWEEP
  } col_sel_t;

  typedef struct packed {
    logic     load;
    logic     home;
    logic     new_line;
    logic     clear_hist;
    logic     locate;
    logic     base;
    logic     cursor_inc;
    logic     cursor_dec;
    logic     mark_valid;
    logic     capture;
    logic     mem_we;
    logic     wr_char;
    logic     init_mode;
    logic     init_step;
    logic     sweep_clr;
    logic     sweep_step;
    col_sel_t col_sel;
  } tcsb_cmd_t;

  typedef struct packed {
    logic init_last;
    logic is_put;
    logic is_read;
    logic is_clear;
    logic ch_newline;
    logic ch_return;
    logic ch_backspace;
    logic back_ok;
    logic cursor_zero;
    logic at_last_col;
    logic sweep_last;
  } tcsb_status_t;

endpackage

// ----- rtl/tcsb_ram.sv -----
// Generic single-port RAM with registered read data.
module tcsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 7950
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/tcsb_ctrl.sv -----
// Controller state machine for the scrollback buffer.
module tcsb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  tcsb_pkg::tcsb_status_t st,
  output tcsb_pkg::tcsb_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);
  import tcsb_pkg::*;

  state_t state, state_next;
  job_t   job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      job   <= JOB_CHAR;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    cmd        = '0;
    cmd.col_sel = COL_CURSOR;
    unique case (state)
      S_INIT: begin
        cmd.init_mode = 1'b1;
        cmd.mem_we    = 1'b1;
        cmd.init_step = 1'b1;
        if (st.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        if (st.is_put) begin
          if (st.ch_newline) begin
            cmd.new_line = 1'b1;
            job_next     = JOB_BLANK;
            state_next   = S_LOCATE;
          end else if (st.ch_return) begin
            cmd.home = 1'b1;
          end else if (st.ch_backspace) begin
            if (!st.cursor_zero) begin
              job_next   = JOB_BS;
              state_next = S_LOCATE;
            end
          end else begin
            job_next   = JOB_CHAR;
            state_next = S_LOCATE;
          end
        end else if (st.is_read) begin
          if (st.back_ok) begin
            job_next   = JOB_READ;
            state_next = S_LOCATE;
          end
        end else if (st.is_clear) begin
          cmd.clear_hist = 1'b1;
          job_next       = JOB_BLANK;
          state_next     = S_LOCATE;
        end
      end
      S_NEWLINE: begin
        cmd.new_line = 1'b1;
        job_next     = JOB_BLANK;
        state_next   = S_LOCATE;
      end
      S_LOCATE: begin
        cmd.locate = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.base      = 1'b1;
        cmd.sweep_clr = 1'b1;
        unique case (job)
          JOB_CHAR:  state_next = S_PUT;
          JOB_BS:    state_next = S_BS;
          JOB_READ:  state_next = S_READ;
          JOB_BLANK: state_next = S_BLANK;
          default:   state_next = S_DONE;
        endcase
      end
      S_PUT: begin
        cmd.mem_we     = 1'b1;
        cmd.wr_char    = 1'b1;
        cmd.col_sel    = COL_CURSOR;
        cmd.cursor_inc = 1'b1;
        // wrap to a fresh line once the last column is filled
        state_next = st.at_last_col ? S_NEWLINE : S_DONE;
      end
      S_BS: begin
        cmd.mem_we     = 1'b1;
        cmd.col_sel    = COL_CURSOR_DEC;
        cmd.cursor_dec = 1'b1;
        state_next     = S_DONE;
      end
      S_READ: begin
        cmd.mark_valid = 1'b1;
        cmd.col_sel    = COL_READ;
        state_next     = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_BLANK: begin
        cmd.mem_we     = 1'b1;
        cmd.col_sel    = COL_SWEEP;
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ----- rtl/tcsb_datapath.sv -----
// Datapath: history ring state, cell address generation and cell store.
module tcsb_datapath #(
  parameter int LINE_WIDTH    = 53,
  parameter int HISTORY_LINES = 150
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tcsb_pkg::tcsb_cmd_t     cmd,
  output tcsb_pkg::tcsb_status_t  st,
  input  logic [1:0]             req_type,
  input  logic [7:0]             char_code,
  input  logic [7:0]             char_color,
  input  logic [7:0]             lines_back,
  input  logic [5:0]             read_column,
  output logic [7:0]             cell_char,
  output logic [7:0]             cell_color,
  output logic                   cell_valid,
  output logic [5:0]             cursor_column,
  output logic [7:0]             lines_held
);
  import tcsb_pkg::*;

  localparam int DEPTH = LINE_WIDTH * HISTORY_LINES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(HISTORY_LINES);
  localparam int CW    = $clog2(HISTORY_LINES + 1);
  localparam int COLW  = $clog2(LINE_WIDTH);
  localparam int RCW   = (COLW > 6) ? COLW : 6;
  localparam int BW    = (CW > 8) ? CW : 8;
  localparam int SW    = BW + 1;

  logic [PW-1:0]   oldest;
  logic [CW-1:0]   count;
  logic [COLW-1:0] cursor;
  logic [AW-1:0]   init_ptr;
  logic [COLW-1:0] sweep;
  logic [PW-1:0]   line_phys;
  logic [AW-1:0]   line_base;

  logic [1:0]      req_q;
  logic [7:0]      ch_q;
  logic [7:0]      color_q;
  logic [7:0]      back_q;
  logic [5:0]      rcol_q;

  logic [BW-1:0]   back_x;
  logic [BW-1:0]   count_x;
  logic [BW-1:0]   back_sel;
  logic [BW-1:0]   logical;
  logic [SW-1:0]   sum;
  logic [SW-1:0]   phys_mod;
  logic [RCW-1:0]  rcol_x;
  logic [RCW-1:0]  cur_x;
  logic            col_ok;
  logic [COLW-1:0] col;
  logic [AW-1:0]   addr;
  logic [15:0]     wdata;
  logic [15:0]     rdata;

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest   <= '0;
      count    <= CW'(1);
      cursor   <= '0;
      init_ptr <= '0;
    end else begin
      if (cmd.init_step) init_ptr <= init_ptr + AW'(1);
      if (cmd.home) cursor <= '0;
      if (cmd.cursor_inc) cursor <= cursor + COLW'(1);
      if (cmd.cursor_dec) cursor <= cursor - COLW'(1);
      if (cmd.new_line) begin
        cursor <= '0;
        if (count < CW'(HISTORY_LINES)) begin
          count <= count + CW'(1);
        end else begin
          // drop the oldest line by advancing the ring head
          oldest <= (oldest == PW'(HISTORY_LINES - 1)) ? '0 : oldest + PW'(1);
        end
      end
      if (cmd.clear_hist) begin
        oldest <= '0;
        count  <= CW'(1);
        cursor <= '0;
      end
    end
  end

  // request fields, line location and sweep counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req_type;
      ch_q    <= char_code;
      color_q <= char_color;
      back_q  <= lines_back;
      rcol_q  <= read_column;
    end
    if (cmd.locate) line_phys <= phys_mod[PW-1:0];
    if (cmd.base) line_base <= AW'(line_phys) * AW'(LINE_WIDTH);
    if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_step) begin
      sweep <= sweep + COLW'(1);
    end
  end

  // result cell
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_char  <= '0;
      cell_color <= '0;
      cell_valid <= 1'b0;
    end else begin
      if (cmd.mark_valid) cell_valid <= 1'b1;
      if (cmd.capture && col_ok) begin
        cell_char  <= rdata[15:8];
        cell_color <= rdata[7:0];
      end
    end
  end

  assign back_x   = BW'(back_q);
  assign count_x  = BW'(count);
  assign back_sel = (req_q == REQ_READ) ? back_x : '0;
  assign logical  = count_x - BW'(1) - back_sel;
  assign sum      = SW'(oldest) + SW'(logical);
  assign phys_mod = (sum >= SW'(HISTORY_LINES)) ? sum - SW'(HISTORY_LINES) : sum;

  assign rcol_x = RCW'(rcol_q);
  assign col_ok = ({1'b0, rcol_x} < (RCW + 1)'(LINE_WIDTH));
  assign cur_x  = RCW'(cursor);

  always_comb begin
    case (cmd.col_sel)
      COL_CURSOR:     col = cursor;
      COL_CURSOR_DEC: col = cursor - COLW'(1);
      COL_READ:       col = rcol_x[COLW-1:0];
      COL_SWEEP:      col = sweep;
      default:        col = cursor;
    endcase
  end

  assign addr  = cmd.init_mode ? init_ptr : line_base + AW'(col);
  assign wdata = cmd.wr_char ? {ch_q, color_q} : 16'd0;

  tcsb_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (cmd.mem_we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign st.init_last    = (init_ptr == AW'(DEPTH - 1));
  assign st.is_put       = (req_q == REQ_PUT);
  assign st.is_read      = (req_q == REQ_READ);
  assign st.is_clear     = (req_q == REQ_CLEAR);
  assign st.ch_newline   = (ch_q == CH_NEWLINE);
  assign st.ch_return    = (ch_q == CH_RETURN);
  assign st.ch_backspace = (ch_q == CH_BACKSPACE);
  assign st.back_ok      = (back_x < count_x);
  assign st.cursor_zero  = (cursor == '0);
  assign st.at_last_col  = (cursor == COLW'(LINE_WIDTH - 1));
  assign st.sweep_last   = (sweep == COLW'(LINE_WIDTH - 1));

  assign cursor_column = cur_x[5:0];
  assign lines_held    = count_x[7:0];

endmodule

// ----- rtl/text_console_scrollback_buffer_core.sv -----
// Top level of the text console scrollback buffer.
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and must be taken then, since there is
// no back-pressure on the result side. Return, unused codes, backspace at
// column 0 and reads beyond the history go from decode straight to done. A
// printed byte, a backspace, a read, a newline or a clear first locates its
// line and forms the line's base address, then writes, reads or blanks cells;
// a printed byte that fills the last column goes on to a newline. busy drops
// in the cycle after done. The single-port cell store clears a fresh line one
// cell per cycle. After reset the store is cleared one cell per cycle, all
// LINE_WIDTH * HISTORY_LINES cells (7950 at the default size), with busy high.
module text_console_scrollback_buffer_core #(
  parameter int LINE_WIDTH    = 53,
  parameter int HISTORY_LINES = 150
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  logic [1:0] req_type,
  input  logic [7:0] char_code,
  input  logic [7:0] char_color,
  input  logic [7:0] lines_back,
  input  logic [5:0] read_column,
  output logic [7:0] cell_char,
  output logic [7:0] cell_color,
  output logic       cell_valid,
  output logic [5:0] cursor_column,
  output logic [7:0] lines_held
);
  import tcsb_pkg::*;

  tcsb_cmd_t    cmd;
  tcsb_status_t st;

  tcsb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tcsb_datapath #(
    .LINE_WIDTH    (LINE_WIDTH),
    .HISTORY_LINES (HISTORY_LINES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .req_type      (req_type),
    .char_code     (char_code),
    .char_color    (char_color),
    .lines_back    (lines_back),
    .read_column   (read_column),
    .cell_char     (cell_char),
    .cell_color    (cell_color),
    .cell_valid    (cell_valid),
    .cursor_column (cursor_column),
    .lines_held    (lines_held)
  );

endmodule
